// ===== src/pidsep_pkg.sv =====
// Package: item types, command and status structs, shared constants for the PID unit.
`timescale 1ns / 1ps
package pidsep_pkg;

  localparam int unsigned ERROR_LIMIT = 32767;
  localparam int unsigned DEAD_BAND   = 0;
  // floor(x / 10) for x below 2^33 is floor((x >> 1) * DELTA_RECIP / 2^34)
  localparam logic [31:0] DELTA_RECIP = 32'hCCCC_CCCD;

  localparam int unsigned DIVD_W = 46;
  localparam int unsigned DIVS_W = 16;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_DRIVE  = 3'd4,
    REG_INTEG  = 3'd5,
    REG_THRESH = 3'd6,
    REG_ALPHA  = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DECAY,
    MUL_ADIFF,
    MUL_SPAN,
    MUL_PE,
    MUL_IA,
    MUL_FD,
    MUL_DP,
    MUL_IE,
    MUL_DD
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_ADD_SH
  } acc_op_e;

  typedef enum logic [1:0] {
    IA_HOLD,
    IA_CLEAR,
    IA_UPDATE
  } ia_op_e;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [30:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic     load;
    acc_op_e  acc_op;
    mul_sel_e mul_sel;
    logic     t_load;
    logic     fd_load;
    logic     div_start;
    ia_op_e   ia_op;
    logic     fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic sep;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/pidsep_stream_if.sv =====
// Interface: valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps
interface pidsep_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pidsep_div.sv =====
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module pidsep_div import pidsep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIVD_W + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] den_q, den_d;
  logic [DIVS_W:0]   trial;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q, quo_q[DIVD_W-1]};
    if (start_i) begin
      cnt_d = CntW'(DIVD_W);
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = DIVS_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

// ===== src/pidsep_dp.sv =====
// Datapath: config registers, state, shared multiplier, accumulator, divider, output register.
`timescale 1ns / 1ps
module pidsep_dp import pidsep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  input  in_item_t  in_data_i,
  input  logic      cfg_we_i,
  input  cfg_item_t cfg_data_i,
  output out_item_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  localparam logic signed [16:0] ErrHi = 17'(ERROR_LIMIT);
  localparam logic signed [16:0] ErrLo = -17'(ERROR_LIMIT);

  function automatic logic signed [63:0] clamp64(logic signed [63:0] x, logic [30:0] b);
    logic signed [63:0] bs;
    bs = {33'b0, b};
    if (x > bs) return bs;
    if (x < -bs) return -bs;
    return x;
  endfunction

  logic        mode_q;
  logic [23:0] gp_q, gi_q, gd_q;
  logic [30:0] lim_q, ilim_q;
  logic [15:0] thr_q;
  logic [16:0] alpha_q;

  logic signed [15:0] e_q, pe_q, ppe_q;
  logic [14:0]        mag_q;
  logic signed [31:0] ia_q, held_q;
  logic signed [33:0] fd_q, t_q;
  logic signed [59:0] prod_q;
  logic signed [61:0] acc_q;
  logic signed [31:0] out_q;
  logic               out_valid_q;
  logic [30:0]        dlim_q;

  logic signed [16:0] raw_err, clip_err;
  logic [16:0]        raw_mag;
  logic [16:0]        a_eff, a_inv;
  logic signed [16:0] diff, span;
  logic signed [17:0] dd;
  logic signed [24:0] mul_a;
  logic signed [34:0] mul_b;
  logic               sep;

  logic [DIVD_W-1:0]  div_dividend, div_quo;
  logic [DIVS_W-1:0]  div_divisor;
  logic               div_busy;
  logic [32:0]        lim3;
  logic [63:0]        dlim_prod;

  logic signed [33:0] ia_inc, ia_sum;
  logic signed [63:0] d_pos, d_delta, d_held, d_inc;
  logic signed [31:0] drive;

  always_comb begin
    raw_err  = {in_data_i.target[15], in_data_i.target}
             - {in_data_i.measured[15], in_data_i.measured};
    clip_err = raw_err;
    if (raw_err > ErrHi) clip_err = ErrHi;
    if (raw_err < ErrLo) clip_err = ErrLo;
    raw_mag  = clip_err[16] ? 17'(-clip_err) : 17'(clip_err);
    if (raw_mag <= 17'(DEAD_BAND)) begin
      clip_err = '0;
      raw_mag  = '0;
    end
  end

  assign a_eff = (alpha_q > 17'd65536) ? 17'd65536 : alpha_q;
  assign a_inv = 17'(18'd65536 - {1'b0, a_eff});
  assign diff  = {e_q[15], e_q} - {pe_q[15], pe_q};
  assign dd    = {{2{e_q[15]}}, e_q} - {pe_q[15], pe_q, 1'b0} + {{2{ppe_q[15]}}, ppe_q};
  assign span  = {1'b0, thr_q} - {2'b0, mag_q};
  assign sep   = ({1'b0, mag_q} >= thr_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_DECAY: begin mul_a = {8'b0, a_inv};            mul_b = {fd_q[33], fd_q}; end
      MUL_ADIFF: begin mul_a = {8'b0, a_eff};            mul_b = {{18{diff[16]}}, diff}; end
      MUL_SPAN:  begin mul_a = {{8{span[16]}}, span};    mul_b = {20'b0, mag_q}; end
      MUL_PE:    begin mul_a = {1'b0, gp_q};             mul_b = {{19{e_q[15]}}, e_q}; end
      MUL_IA:    begin mul_a = {1'b0, gi_q};             mul_b = {{3{ia_q[31]}}, ia_q}; end
      MUL_FD:    begin mul_a = {1'b0, gd_q};             mul_b = {fd_q[33], fd_q}; end
      MUL_DP:    begin mul_a = {1'b0, gp_q};             mul_b = {{18{diff[16]}}, diff}; end
      MUL_IE:    begin mul_a = {1'b0, gi_q};             mul_b = {{19{e_q[15]}}, e_q}; end
      MUL_DD:    begin mul_a = {1'b0, gd_q};             mul_b = {{17{dd[17]}}, dd}; end
      default:   begin mul_a = '0;                       mul_b = '0; end
    endcase
  end

  assign lim3         = {2'b0, lim_q} + {1'b0, lim_q, 1'b0};
  assign dlim_prod    = {32'b0, lim3[32:1]} * {32'b0, DELTA_RECIP};
  assign div_dividend = {prod_q[29:0], 16'b0};
  assign div_divisor  = thr_q;

  pidsep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign ia_inc = e_q[15] ? -{2'b0, div_quo[31:0]} : {2'b0, div_quo[31:0]};
  assign ia_sum = {{2{ia_q[31]}}, ia_q} + ia_inc;

  always_comb begin
    d_pos   = clamp64({{18{acc_q[61]}}, acc_q[61:16]}, lim_q);
    d_delta = clamp64({{2{acc_q[61]}}, acc_q}, dlim_q);
    d_held  = clamp64({{32{held_q[31]}}, held_q}, lim_q);
    d_inc   = clamp64(d_held + d_delta, lim_q);
    drive   = mode_q ? d_inc[31:0] : d_pos[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      gp_q    <= '0;
      gi_q    <= '0;
      gd_q    <= '0;
      lim_q   <= '0;
      ilim_q  <= '0;
      thr_q   <= '0;
      alpha_q <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_data_i.index))
        REG_MODE:   mode_q  <= cfg_data_i.value[0];
        REG_GAIN_P: gp_q    <= cfg_data_i.value[23:0];
        REG_GAIN_I: gi_q    <= cfg_data_i.value[23:0];
        REG_GAIN_D: gd_q    <= cfg_data_i.value[23:0];
        REG_DRIVE:  lim_q   <= cfg_data_i.value;
        REG_INTEG:  ilim_q  <= cfg_data_i.value;
        REG_THRESH: thr_q   <= cfg_data_i.value[15:0];
        REG_ALPHA:  alpha_q <= cfg_data_i.value[16:0];
        default:    mode_q  <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q        <= '0;
      ppe_q       <= '0;
      ia_q        <= '0;
      fd_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      dlim_q      <= '0;
    end else begin
      dlim_q <= {1'b0, dlim_prod[63:34]};
      if (cmd_i.fd_load) fd_q <= prod_q[33:0] + t_q;
      case (cmd_i.ia_op)
        IA_CLEAR:  ia_q <= '0;
        IA_UPDATE: ia_q <= 32'(clamp64({{30{ia_sum[33]}}, ia_sum}, ilim_q));
        default:   ia_q <= ia_q;
      endcase
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        held_q      <= drive;
        pe_q        <= e_q;
        if (mode_q) ppe_q <= pe_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e_q   <= clip_err[15:0];
      mag_q <= raw_mag[14:0];
    end
    if (cmd_i.mul_sel != MUL_NONE) prod_q <= mul_a * mul_b;
    if (cmd_i.t_load) t_q <= prod_q[49:16];
    case (cmd_i.acc_op)
      ACC_CLR:    acc_q <= '0;
      ACC_ADD:    acc_q <= acc_q + {{2{prod_q[59]}}, prod_q};
      ACC_ADD_SH: acc_q <= acc_q + {prod_q[45:0], 16'b0};
      default:    acc_q <= acc_q;
    endcase
    if (cmd_i.fin) out_q <= drive;
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.sep      = sep;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_data_o.drive = out_q;
  assign out_valid_o      = out_valid_q;

endmodule

// ===== src/pidsep_ctrl.sv =====
// Controller: sequences the datapath through one control step per item.
`timescale 1ns / 1ps
module pidsep_ctrl import pidsep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_P_DECAY = 4'd1;
  localparam logic [3:0] ST_P_ADIFF = 4'd2;
  localparam logic [3:0] ST_P_FDSUM = 4'd3;
  localparam logic [3:0] ST_P_SPLIT = 4'd4;
  localparam logic [3:0] ST_P_WAIT  = 4'd5;
  localparam logic [3:0] ST_P_MP    = 4'd6;
  localparam logic [3:0] ST_P_MI    = 4'd7;
  localparam logic [3:0] ST_P_MD    = 4'd8;
  localparam logic [3:0] ST_P_ACC   = 4'd9;
  localparam logic [3:0] ST_I_MP    = 4'd10;
  localparam logic [3:0] ST_I_MI    = 4'd11;
  localparam logic [3:0] ST_I_MD    = 4'd12;
  localparam logic [3:0] ST_I_ACC   = 4'd13;
  localparam logic [3:0] ST_FIN     = 4'd15;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.acc_op    = ACC_HOLD;
    cmd_o.mul_sel   = MUL_NONE;
    cmd_o.ia_op     = IA_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load   = 1'b1;
          cmd_o.acc_op = ACC_CLR;
          state_d      = stat_i.mode ? ST_I_MP : ST_P_DECAY;
        end
      end
      ST_P_DECAY: begin
        cmd_o.mul_sel = MUL_DECAY;
        state_d       = ST_P_ADIFF;
      end
      ST_P_ADIFF: begin
        cmd_o.t_load  = 1'b1;
        cmd_o.mul_sel = MUL_ADIFF;
        state_d       = ST_P_FDSUM;
      end
      ST_P_FDSUM: begin
        cmd_o.fd_load = 1'b1;
        cmd_o.mul_sel = MUL_SPAN;
        state_d       = ST_P_SPLIT;
      end
      ST_P_SPLIT: begin
        if (stat_i.sep) begin
          cmd_o.ia_op = IA_CLEAR;
          state_d     = ST_P_MP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_P_WAIT;
        end
      end
      ST_P_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.ia_op = IA_UPDATE;
          state_d     = ST_P_MP;
        end
      end
      ST_P_MP: begin
        cmd_o.mul_sel = MUL_PE;
        state_d       = ST_P_MI;
      end
      ST_P_MI: begin
        cmd_o.acc_op  = ACC_ADD_SH;
        cmd_o.mul_sel = MUL_IA;
        state_d       = ST_P_MD;
      end
      ST_P_MD: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_sel = MUL_FD;
        state_d       = ST_P_ACC;
      end
      ST_P_ACC: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_FIN;
      end
      ST_I_MP: begin
        cmd_o.mul_sel = MUL_DP;
        state_d       = ST_I_MI;
      end
      ST_I_MI: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_sel = MUL_IE;
        state_d       = ST_I_MD;
      end
      ST_I_MD: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_sel = MUL_DD;
        state_d       = ST_I_ACC;
      end
      ST_I_ACC: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/pid_with_integral_separation_unit.sv =====
// Top level: PID controller with integral separation, controller plus datapath.
//
//   channel  dir  payload                         accepted when
//   in_i     in   target, measured (s16 each)     in_i.valid && in_i.ready
//   out_o    out  drive (s32, Q16.16)             out_o.valid && out_o.ready
//   cfg_i    in   index (3 b), value (31 b)       cfg_i.valid && cfg_i.ready
//
// One item at a time; ready rises again in the same cycle that its result enters the output register.
// Positional mode: below the threshold the 46-step restoring divider forms the integral
// increment; at or above it the integral is cleared and the divider is not started.
// Incremental mode: the delta bound is a registered constant reciprocal multiply of the
// drive limit. Reset clears config and state, but not the work or output data registers;
// alpha comes up as one. A stalled output holds the next result in the controller until the
// register frees; config is always ready.
`timescale 1ns / 1ps
module pid_with_integral_separation_unit import pidsep_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  pidsep_stream_if.sink   in_i,
  pidsep_stream_if.source out_o,
  pidsep_stream_if.sink   cfg_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  in_item_t  in_data;
  cfg_item_t cfg_data;
  out_item_t out_data;
  logic      in_ready;

  assign in_data    = in_i.data;
  assign cfg_data   = cfg_i.data;
  assign in_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.data = out_data;

  pidsep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pidsep_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_data),
    .out_data_o  (out_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_ready |=> !in_ready)
    else $error("input taken again straight after an item");

  a_div_free_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !stat.div_busy)
    else $error("divider still running while idle");

  a_fin_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> !stat.out_busy)
    else $error("result written over a waiting item");

endmodule
